// ----- hdl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and constants of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned WAKE_W    = 62;
  localparam int unsigned ALU_W     = 63;

  localparam logic [29:0] NS_MAX  = 30'd999999999;
  localparam logic [30:0] NS_WRAP = 31'd1000000000;

  localparam logic [2:0] ST_ALIVE   = 3'h1;
  localparam logic [2:0] ST_SLEEP   = 3'h2;
  localparam logic [2:0] ST_SUSPEND = 3'h4;

  localparam logic [2:0] CMD_SCHED   = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_KILL    = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME  = 3'd4;
  localparam logic [2:0] CMD_SLEEP   = 3'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             cin;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             cout;
  } alu_rsp_t;

  typedef struct packed {
    logic status;
    logic nxt;
    logic wake;
  } store_we_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  thread_id;
    logic [31:0] sleep_seconds;
    logic [29:0] sleep_nanoseconds;
    logic [31:0] now_seconds;
    logic [29:0] now_nanoseconds;
  } in_item_t;

  typedef struct packed {
    logic [3:0] running_id;
    logic       ready_found;
    logic       rescheduled;
    logic [3:0] created_id;
    logic       create_ok;
  } out_item_t;

endpackage

// ----- hdl/rrts_time_alu.sv -----
// ----------------------------------------------------------------------------
// rrts_time_alu
// Shared adder/subtractor for wake time sums, carry normalization and the
// due check of the ring walk.
// ----------------------------------------------------------------------------
module rrts_time_alu (
  input  rrts_pkg::alu_req_t req_i,
  output rrts_pkg::alu_rsp_t rsp_o
);
  import rrts_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic             c_in;
  logic [ALU_W:0]   full;

  // Subtraction is a plus the inverse of b plus one; carry out means no borrow.
  always_comb begin
    b_op = (req_i.op == ALU_SUB) ? ~req_i.b : req_i.b;
    c_in = (req_i.op == ALU_SUB) ? 1'b1 : req_i.cin;
    full = {1'b0, req_i.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, c_in};
  end

  assign rsp_o.sum  = full[ALU_W-1:0];
  assign rsp_o.cout = full[ALU_W];

endmodule

// ----- hdl/rrts_slot_store.sv -----
// ----------------------------------------------------------------------------
// rrts_slot_store
// Per-slot status, ring successor and wake time memories with one shared
// registered read port and one shared write address.
// ----------------------------------------------------------------------------
module rrts_slot_store #(
  parameter int unsigned SLOTS = rrts_pkg::SLOTS_DEF,
  localparam int unsigned IW   = $clog2(SLOTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [IW-1:0]               raddr_i,
  input  rrts_pkg::store_we_t         we_i,
  input  logic [IW-1:0]               waddr_i,
  input  logic [2:0]                  wstatus_i,
  input  logic [IW-1:0]               wnext_i,
  input  logic [rrts_pkg::WAKE_W-1:0] wwake_i,
  output logic [2:0]                  rstatus_o,
  output logic [IW-1:0]               rnext_o,
  output logic [rrts_pkg::WAKE_W-1:0] rwake_o
);
  import rrts_pkg::*;

  logic [2:0]        status_mem [SLOTS];
  logic [IW-1:0]     next_mem   [SLOTS];
  logic [WAKE_W-1:0] wake_mem   [SLOTS];

  logic [2:0]        status_rd_q;
  logic [IW-1:0]     next_rd_q;
  logic [WAKE_W-1:0] wake_rd_q;

  // Only slot 0 has a nonzero reset state that is ever read; every other
  // slot is written by create before the ring can reach it.
  logic v_status_q, v_next_q, v_wake_q;
  logic dflt_status_q, dflt_next_q, dflt_wake_q;

  always_ff @(posedge clk_i) begin
    if (we_i.status) status_mem[waddr_i] <= wstatus_i;
    if (we_i.nxt)    next_mem[waddr_i]   <= wnext_i;
    if (we_i.wake)   wake_mem[waddr_i]   <= wwake_i;
    status_rd_q <= status_mem[raddr_i];
    next_rd_q   <= next_mem[raddr_i];
    wake_rd_q   <= wake_mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_status_q    <= 1'b0;
      v_next_q      <= 1'b0;
      v_wake_q      <= 1'b0;
      dflt_status_q <= 1'b1;
      dflt_next_q   <= 1'b1;
      dflt_wake_q   <= 1'b1;
    end else begin
      if (we_i.status && (waddr_i == '0)) v_status_q <= 1'b1;
      if (we_i.nxt && (waddr_i == '0))    v_next_q   <= 1'b1;
      if (we_i.wake && (waddr_i == '0))   v_wake_q   <= 1'b1;
      dflt_status_q <= (raddr_i == '0) && !v_status_q;
      dflt_next_q   <= (raddr_i == '0) && !v_next_q;
      dflt_wake_q   <= (raddr_i == '0) && !v_wake_q;
    end
  end

  assign rstatus_o = dflt_status_q ? ST_ALIVE : status_rd_q;
  assign rnext_o   = dflt_next_q ? '0 : next_rd_q;
  assign rwake_o   = dflt_wake_q ? '0 : wake_rd_q;

endmodule

// ----- hdl/round_robin_thread_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Round-robin thread scheduler over a ring of slots with sleep and wakeup.
// ----------------------------------------------------------------------------
// One transaction is taken when start is high and busy is low; its result
// appears on result_o with done_o, high for exactly one cycle, in the cycle
// in which busy falls, and cannot be held off. A schedule tick walks 1 to
// SLOTS ring entries, one per cycle through the slot store's read port, with
// the shared time unit checking each entry's wake time. Kill, suspend and
// resume read the target's status and write it back, then walk the ring if
// they target the current slot; sleep does so after forming the wake time in
// three passes through the time unit. Create reads the current slot's
// successor, writes the new slot, links it in; other commands use a no-op
// state. Reset needs no clearing pass; the block is ready right after reset.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core #(
  parameter int unsigned SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  rrts_pkg::in_item_t  item_i,
  output logic                busy,
  output logic                done_o,
  output rrts_pkg::out_item_t result_o
);
  import rrts_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned FW = $clog2(SLOTS + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NOP     = 4'd1;
  localparam logic [3:0] S_CR_RD   = 4'd2;
  localparam logic [3:0] S_CR_WR1  = 4'd3;
  localparam logic [3:0] S_CR_WR2  = 4'd4;
  localparam logic [3:0] S_ST_RD   = 4'd5;
  localparam logic [3:0] S_ST_WR   = 4'd6;
  localparam logic [3:0] S_SL_NS   = 4'd7;
  localparam logic [3:0] S_SL_WRAP = 4'd8;
  localparam logic [3:0] S_SL_SEC  = 4'd9;
  localparam logic [3:0] S_WALK0   = 4'd10;
  localparam logic [3:0] S_WALK1   = 4'd11;
  localparam logic [3:0] S_WALK    = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic              done_q, done_d;

  logic [2:0]        cmd_q, cmd_d;
  logic [IW-1:0]     tid_q, tid_d;
  logic [31:0]       sl_s_q, sl_s_d;
  logic [29:0]       sl_ns_q, sl_ns_d;
  logic [31:0]       now_s_q, now_s_d;
  logic [29:0]       now_ns_q, now_ns_d;
  logic [30:0]       t_ns_q, t_ns_d;
  logic [29:0]       ns_norm_q, ns_norm_d;
  logic              cy_q, cy_d;
  logic [WAKE_W-1:0] wake_q, wake_d;
  logic [IW-1:0]     node_q, node_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              found_q, found_d;
  logic              resched_q, resched_d;
  logic [3:0]        cid_q, cid_d;
  logic              cok_q, cok_d;
  out_item_t         res_q, res_d;

  logic              finish;
  logic              tid_ok;
  logic [IW-1:0]     tid_in;
  logic [IW-1:0]     fill_idx;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic [IW-1:0]     raddr;
  store_we_t         we;
  logic [IW-1:0]     waddr;
  logic [2:0]        wstatus;
  logic [IW-1:0]     wnext;
  logic [WAKE_W-1:0] wwake;
  logic [2:0]        rd_status;
  logic [IW-1:0]     rd_next;
  logic [WAKE_W-1:0] rd_wake;

  rrts_time_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  rrts_slot_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .raddr_i   (raddr),
    .we_i      (we),
    .waddr_i   (waddr),
    .wstatus_i (wstatus),
    .wnext_i   (wnext),
    .wwake_i   (wwake),
    .rstatus_o (rd_status),
    .rnext_o   (rd_next),
    .rwake_o   (rd_wake)
  );

  assign tid_ok   = 32'(item_i.thread_id) < SLOTS;
  assign tid_in   = IW'(item_i.thread_id);
  // Slots are handed out in order and never reused, so the fill count is
  // also the lowest unused slot.
  assign fill_idx = fill_q[IW-1:0];

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    fill_d    = fill_q;
    cmd_d     = cmd_q;
    tid_d     = tid_q;
    sl_s_d    = sl_s_q;
    sl_ns_d   = sl_ns_q;
    now_s_d   = now_s_q;
    now_ns_d  = now_ns_q;
    t_ns_d    = t_ns_q;
    ns_norm_d = ns_norm_q;
    cy_d      = cy_q;
    wake_d    = wake_q;
    node_d    = node_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    resched_d = resched_q;
    cid_d     = cid_q;
    cok_d     = cok_q;
    finish    = 1'b0;
    alu_req   = '{op: ALU_ADD, a: '0, b: '0, cin: 1'b0};
    raddr     = '0;
    we        = '0;
    waddr     = '0;
    wstatus   = '0;
    wnext     = '0;
    wwake     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d     = item_i.cmd;
          tid_d     = tid_in;
          sl_s_d    = item_i.sleep_seconds;
          sl_ns_d   = (item_i.sleep_nanoseconds > NS_MAX) ? NS_MAX : item_i.sleep_nanoseconds;
          now_s_d   = item_i.now_seconds;
          now_ns_d  = (item_i.now_nanoseconds > NS_MAX) ? NS_MAX : item_i.now_nanoseconds;
          found_d   = 1'b0;
          resched_d = 1'b0;
          cid_d     = '0;
          cok_d     = 1'b0;
          unique case (item_i.cmd) inside
            CMD_SCHED: begin
              resched_d = 1'b1;
              state_d   = S_WALK0;
            end
            CMD_CREATE: begin
              state_d = (fill_q == FW'(SLOTS)) ? S_NOP : S_CR_RD;
            end
            CMD_KILL, CMD_SUSPEND, CMD_RESUME: begin
              state_d = tid_ok ? S_ST_RD : S_NOP;
            end
            CMD_SLEEP: begin
              state_d = tid_ok ? S_SL_NS : S_NOP;
            end
            default: state_d = S_NOP;
          endcase
        end
      end

      S_NOP: begin
        finish  = 1'b1;
        state_d = S_IDLE;
      end

      S_CR_RD: begin
        raddr   = cur_q;
        state_d = S_CR_WR1;
      end

      S_CR_WR1: begin
        we      = '{status: 1'b1, nxt: 1'b1, wake: 1'b1};
        waddr   = fill_idx;
        wstatus = ST_ALIVE;
        wnext   = rd_next;
        wwake   = '0;
        state_d = S_CR_WR2;
      end

      // The new slot follows the current one and is alive and awake, so the
      // walk would pick it at its first step.
      S_CR_WR2: begin
        we.nxt    = 1'b1;
        waddr     = cur_q;
        wnext     = fill_idx;
        cur_d     = fill_idx;
        cid_d     = 4'(fill_idx);
        cok_d     = 1'b1;
        resched_d = 1'b1;
        found_d   = 1'b1;
        fill_d    = fill_q + FW'(1);
        finish    = 1'b1;
        state_d   = S_IDLE;
      end

      S_ST_RD: begin
        raddr   = tid_q;
        state_d = S_ST_WR;
      end

      S_ST_WR: begin
        we.status = 1'b1;
        waddr     = tid_q;
        unique case (cmd_q)
          CMD_KILL:    wstatus = rd_status & ~ST_ALIVE;
          CMD_SUSPEND: wstatus = rd_status | ST_SUSPEND;
          CMD_RESUME:  wstatus = rd_status & ~ST_SUSPEND;
          CMD_SLEEP: begin
            wstatus = rd_status | ST_SLEEP;
            we.wake = 1'b1;
            wwake   = wake_q;
          end
          default:     wstatus = rd_status;
        endcase
        if (tid_q == cur_q) begin
          resched_d = 1'b1;
          state_d   = S_WALK0;
        end else begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SL_NS: begin
        alu_req = '{op: ALU_ADD, a: ALU_W'(now_ns_q), b: ALU_W'(sl_ns_q), cin: 1'b0};
        t_ns_d  = alu_rsp.sum[30:0];
        state_d = S_SL_WRAP;
      end

      S_SL_WRAP: begin
        alu_req   = '{op: ALU_SUB, a: ALU_W'(t_ns_q), b: ALU_W'(NS_WRAP), cin: 1'b0};
        cy_d      = alu_rsp.cout;
        ns_norm_d = alu_rsp.cout ? alu_rsp.sum[29:0] : t_ns_q[29:0];
        state_d   = S_SL_SEC;
      end

      S_SL_SEC: begin
        alu_req = '{op: ALU_ADD, a: ALU_W'(now_s_q), b: ALU_W'(sl_s_q), cin: cy_q};
        if (alu_rsp.sum[32]) begin
          wake_d = {32'hFFFF_FFFF, NS_MAX};
        end else begin
          wake_d = {alu_rsp.sum[31:0], ns_norm_q};
        end
        raddr   = tid_q;
        state_d = S_ST_WR;
      end

      S_WALK0: begin
        raddr   = cur_q;
        state_d = S_WALK1;
      end

      S_WALK1: begin
        raddr   = rd_next;
        node_d  = rd_next;
        cnt_d   = '0;
        state_d = S_WALK;
      end

      // Entry node_q is on the read port; its successor is fetched at once.
      S_WALK: begin
        alu_req = '{op: ALU_SUB, a: {1'b0, now_s_q, now_ns_q}, b: {1'b0, rd_wake},
                    cin: 1'b0};
        if (((rd_status & ST_SLEEP) != '0) && alu_rsp.cout) begin
          we      = '{status: 1'b1, nxt: 1'b0, wake: 1'b1};
          waddr   = node_q;
          wstatus = rd_status & ~ST_SLEEP;
          wwake   = '0;
          cur_d   = node_q;
          found_d = 1'b1;
          finish  = 1'b1;
          state_d = S_IDLE;
        end else if (((rd_status & (ST_SLEEP | ST_SUSPEND)) == '0) &&
                     ((rd_status & ST_ALIVE) != '0)) begin
          cur_d   = node_q;
          found_d = 1'b1;
          finish  = 1'b1;
          state_d = S_IDLE;
        end else if (cnt_q == IW'(SLOTS - 1)) begin
          found_d = 1'b0;
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr  = rd_next;
          node_d = rd_next;
          cnt_d  = cnt_q + IW'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (finish) begin
      res_d.running_id  = 4'(cur_d);
      res_d.ready_found = found_d;
      res_d.rescheduled = resched_d;
      res_d.created_id  = cid_d;
      res_d.create_ok   = cok_d;
    end
  end

  assign done_d = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      fill_q  <= FW'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    tid_q     <= tid_d;
    sl_s_q    <= sl_s_d;
    sl_ns_q   <= sl_ns_d;
    now_s_q   <= now_s_d;
    now_ns_q  <= now_ns_d;
    t_ns_q    <= t_ns_d;
    ns_norm_q <= ns_norm_d;
    cy_q      <= cy_d;
    wake_q    <= wake_d;
    node_q    <= node_d;
    cnt_q     <= cnt_d;
    found_q   <= found_d;
    resched_q <= resched_d;
    cid_q     <= cid_d;
    cok_q     <= cok_d;
    res_q     <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/rrts_checker.sv -----
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the thread scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input rrts_pkg::out_item_t result_o
);
  import rrts_pkg::*;

  // Every accepted transaction raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_found_needs_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.rescheduled) |-> !result_o.ready_found)
    else $error("ready_found reported without a scheduling walk");

  // A successful create always runs the new thread.
  a_create_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.create_ok) |->
      (result_o.rescheduled && result_o.ready_found &&
       (result_o.running_id == result_o.created_id)))
    else $error("created thread is not the running thread");

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ----- tb/round_robin_thread_scheduler_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core_test
// Self-checking bench for the round-robin thread scheduler. A clocked driver
// issues schedule, create, kill, suspend, resume, sleep and spare commands from a
// queue, and a software copy of the slot ring predicts every result. A clocked
// monitor compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core_test;
  import rrts_pkg::*;

  localparam int unsigned SLOTS = SLOTS_DEF;
  localparam int unsigned RANDOM_CMDS = 1850;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  in_item_t  item = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  round_robin_thread_scheduler_core #(.SLOTS(SLOTS)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item),
    .busy    (busy),
    .done_o  (done),
    .result_o(result)
  );

  // Software copy of the scheduler state.
  logic [2:0]  thr_status  [SLOTS];
  logic        thr_used    [SLOTS];
  logic [3:0]  thr_next    [SLOTS];
  logic [31:0] thr_wake_s  [SLOTS];
  logic [29:0] thr_wake_ns [SLOTS];
  logic [3:0]  cur_thread;

  in_item_t  queued_cmds[$];
  out_item_t pending_outcomes[$];

  int unsigned n_loaded = 0;
  int unsigned phase1_end = 0;
  int unsigned phase2_end = 0;
  int unsigned n_checked = 0;
  int unsigned n_walks = 0;
  int unsigned n_empty_walks = 0;
  int unsigned n_wakes = 0;
  int unsigned n_create_refused = 0;
  int unsigned errors = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Walks the ring from the successor of the current slot; returns 1 when a
  // slot is chosen. A due sleeper is woken and chosen even if not alive.
  function automatic bit walk_ring(input logic [31:0] now_s, input logic [29:0] now_ns);
    logic [3:0] node;
    logic [2:0] st;
    node = thr_next[cur_thread];
    for (int i = 0; i < SLOTS; i++) begin
      st = thr_status[node];
      if ((st & ST_SLEEP) != 3'd0) begin
        if (thr_wake_s[node] < now_s ||
            (thr_wake_s[node] == now_s && thr_wake_ns[node] <= now_ns)) begin
          thr_wake_s[node] = '0;
          thr_wake_ns[node] = '0;
          thr_status[node] = st & ~ST_SLEEP;
          cur_thread = node;
          n_wakes++;
          return 1'b1;
        end
      end else if ((st & ST_SUSPEND) == 3'd0 && (st & ST_ALIVE) != 3'd0) begin
        cur_thread = node;
        return 1'b1;
      end
      node = thr_next[node];
    end
    return 1'b0;
  endfunction

  function automatic out_item_t advance_scheduler(input in_item_t it);
    out_item_t   r;
    logic [31:0] now_s;
    logic [29:0] now_ns;
    logic [29:0] sl_ns;
    logic [3:0]  cur;
    logic [3:0]  tid;
    logic [32:0] sum_s;
    logic [30:0] sum_ns;
    bit          do_walk;
    r = '0;
    do_walk = 1'b0;
    cur = cur_thread;
    tid = it.thread_id;
    now_s = it.now_seconds;
    now_ns = (it.now_nanoseconds > NS_MAX) ? NS_MAX : it.now_nanoseconds;
    sl_ns = (it.sleep_nanoseconds > NS_MAX) ? NS_MAX : it.sleep_nanoseconds;
    if (it.cmd == CMD_SCHED) begin
      do_walk = 1'b1;
    end else if (it.cmd == CMD_CREATE) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!r.create_ok && !thr_used[s]) begin
          thr_used[s] = 1'b1;
          thr_status[s] = ST_ALIVE;
          thr_wake_s[s] = '0;
          thr_wake_ns[s] = '0;
          thr_next[s] = thr_next[cur];
          thr_next[cur] = s[3:0];
          r.created_id = s[3:0];
          r.create_ok = 1'b1;
          do_walk = 1'b1;
        end
      end
      if (!r.create_ok) n_create_refused++;
    end else if (it.cmd <= CMD_SLEEP && int'(tid) < SLOTS) begin
      if (it.cmd == CMD_KILL) begin
        thr_status[tid] = thr_status[tid] & ~ST_ALIVE;
      end else if (it.cmd == CMD_SUSPEND) begin
        thr_status[tid] = thr_status[tid] | ST_SUSPEND;
      end else if (it.cmd == CMD_RESUME) begin
        thr_status[tid] = thr_status[tid] & ~ST_SUSPEND;
      end else begin
        sum_s = {1'b0, now_s} + {1'b0, it.sleep_seconds};
        sum_ns = {1'b0, now_ns} + {1'b0, sl_ns};
        if (sum_ns >= NS_WRAP) begin
          sum_ns = sum_ns - NS_WRAP;
          sum_s = sum_s + 33'd1;
        end
        // Wake times past the 32-bit seconds range pin to the latest time.
        if (sum_s[32]) begin
          sum_s = {1'b0, 32'hFFFF_FFFF};
          sum_ns = {1'b0, NS_MAX};
        end
        thr_wake_s[tid] = sum_s[31:0];
        thr_wake_ns[tid] = sum_ns[29:0];
        thr_status[tid] = thr_status[tid] | ST_SLEEP;
      end
      if (tid == cur) do_walk = 1'b1;
    end
    if (do_walk) begin
      n_walks++;
      r.ready_found = walk_ring(now_s, now_ns);
      if (!r.ready_found) n_empty_walks++;
    end
    r.rescheduled = do_walk;
    r.running_id = cur_thread;
    return r;
  endfunction

  function automatic in_item_t make_cmd(input logic [2:0] c, input logic [3:0] tid,
                                        input logic [31:0] ss, input logic [29:0] sns,
                                        input logic [31:0] ns, input logic [29:0] nns);
    in_item_t it;
    it.cmd = c;
    it.thread_id = tid;
    it.sleep_seconds = ss;
    it.sleep_nanoseconds = sns;
    it.now_seconds = ns;
    it.now_nanoseconds = nns;
    return it;
  endfunction

  // Driver: a transaction is taken at an edge where start is high and busy low.
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    int unsigned idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
      item <= '0;
    end else begin
      if (start && !busy) pending_outcomes.push_back(advance_scheduler(item));
      if (!start || !busy) begin
        idle_pct = (n_loaded < phase1_end) ? 28 : (n_loaded < phase2_end) ? 74 : 0;
        if (queued_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          item <= queued_cmds.pop_front();
          n_loaded++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    if (rst_ni && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result strobed with no outstanding transaction");
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (result.running_id !== want.running_id) begin
          $error("running_id: expected %0d, actual %0d", want.running_id, result.running_id);
          errors++;
        end
        if (result.ready_found !== want.ready_found) begin
          $error("ready_found: expected %0b, actual %0b", want.ready_found, result.ready_found);
          errors++;
        end
        if (result.rescheduled !== want.rescheduled) begin
          $error("rescheduled: expected %0b, actual %0b", want.rescheduled, result.rescheduled);
          errors++;
        end
        if (result.created_id !== want.created_id) begin
          $error("created_id: expected %0d, actual %0d", want.created_id, result.created_id);
          errors++;
        end
        if (result.create_ok !== want.create_ok) begin
          $error("create_ok: expected %0b, actual %0b", want.create_ok, result.create_ok);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] t_s;
    logic [30:0] t_ns;
    logic [2:0]  c;
    logic [3:0]  tid;
    logic [31:0] ss;
    logic [29:0] sns;
    logic [31:0] ns;
    logic [29:0] nns;
    int unsigned roll;

    for (int s = 0; s < SLOTS; s++) begin
      thr_status[s] = 3'd0;
      thr_used[s] = 1'b0;
      thr_next[s] = 4'd0;
      thr_wake_s[s] = '0;
      thr_wake_ns[s] = '0;
    end
    thr_status[0] = ST_ALIVE;
    thr_used[0] = 1'b1;
    cur_thread = 4'd0;

    // Directed part: lone slot 0, creates, spare opcodes, suspend and resume,
    // an immediately due sleep, a wake time that saturates, a nanosecond
    // carry, out-of-range nanoseconds, edits of slots outside the ring, and a
    // killed sleeper that is still woken and chosen.
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, '0, '0));
    queued_cmds.push_back(make_cmd(CMD_CREATE, 4'd0, '0, '0, 32'd1, '0));
    queued_cmds.push_back(make_cmd(CMD_CREATE, 4'd0, '0, '0, 32'd2, '0));
    queued_cmds.push_back(make_cmd(CMD_SPARE6, 4'hF, '1, NS_MAX, '1, NS_MAX));
    queued_cmds.push_back(make_cmd(CMD_SPARE7, 4'd0, '1, '1, '1, '1));
    queued_cmds.push_back(make_cmd(CMD_SUSPEND, 4'd0, '0, '0, 32'd3, '0));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, 32'd4, '0));
    queued_cmds.push_back(make_cmd(CMD_RESUME, 4'd0, '0, '0, 32'd5, '0));
    queued_cmds.push_back(make_cmd(CMD_SLEEP, 4'd1, '0, '0, 32'd10, '0));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, 32'd10, '0));
    queued_cmds.push_back(make_cmd(CMD_SLEEP, 4'd2, '1, NS_MAX, '1, NS_MAX));
    queued_cmds.push_back(make_cmd(CMD_SLEEP, 4'd0, 32'd1, 30'd200000000,
                                   32'd20, 30'd900000000));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, 32'd22, 30'd99999999));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, 32'd22, 30'd100000000));
    queued_cmds.push_back(make_cmd(CMD_SLEEP, 4'd3, 32'd5, '1, 32'd30, '1));
    queued_cmds.push_back(make_cmd(CMD_KILL, 4'd9, '0, '0, 32'd31, '0));
    queued_cmds.push_back(make_cmd(CMD_SUSPEND, 4'd3, '0, '0, 32'd32, '0));
    queued_cmds.push_back(make_cmd(CMD_RESUME, 4'd3, '0, '0, 32'd33, '0));
    queued_cmds.push_back(make_cmd(CMD_KILL, 4'd2, '0, '0, 32'd34, '0));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, '1, '1));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, 32'd40, '0));
    queued_cmds.push_back(make_cmd(CMD_KILL, 4'd1, '0, '0, 32'd41, '0));
    queued_cmds.push_back(make_cmd(CMD_SCHED, 4'd0, '0, '0, 32'd42, '0));

    // Random part: a mostly advancing clock with short sleeps, so sleepers
    // become due, mixed with wild times and long intervals as noise.
    t_s = 32'd50;
    t_ns = '0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      t_ns = t_ns + 31'($urandom_range(0, 400000000));
      if (t_ns >= NS_WRAP) begin
        t_ns = t_ns - NS_WRAP;
        t_s = t_s + 32'd1;
      end
      t_s = t_s + 32'($urandom_range(0, 1));
      ns = t_s;
      nns = t_ns[29:0];
      if ($urandom_range(99) < 8) begin
        ns = $urandom;
        nns = 30'($urandom_range(0, 30'h3FFFFFFF));
      end
      roll = $urandom_range(99);
      if (roll < 34) c = CMD_SCHED;
      else if (roll < 40) c = CMD_CREATE;
      else if (roll < 42) c = CMD_KILL;
      else if (roll < 52) c = CMD_SUSPEND;
      else if (roll < 64) c = CMD_RESUME;
      else if (roll < 95) c = CMD_SLEEP;
      else c = ($urandom_range(1) != 0) ? CMD_SPARE7 : CMD_SPARE6;
      tid = ($urandom_range(99) < 60) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
      roll = $urandom_range(99);
      ss = 32'($urandom_range(0, 3));
      sns = 30'($urandom_range(0, NS_MAX));
      if (roll < 10) sns = 30'($urandom_range(NS_WRAP, 30'h3FFFFFFF));
      else if (roll < 20) ss = $urandom;
      queued_cmds.push_back(make_cmd(c, tid, ss, sns, ns, nns));
    end

    phase1_end = queued_cmds.size() / 3;
    phase2_end = 2 * queued_cmds.size() / 3;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_cmds.size() != 0 || start || pending_outcomes.size() != 0)
      @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      errors++;
    end

    $display("Checked %0d results over %0d commands; %0d ring walks, %0d found nothing.",
             n_checked, n_loaded, n_walks, n_empty_walks);
    $display("Sleepers woken: %0d, creates refused for lack of a slot: %0d.",
             n_wakes, n_create_refused);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rrts_pkg.sv
hdl/rrts_time_alu.sv
hdl/rrts_slot_store.sv
hdl/round_robin_thread_scheduler_core.sv
hdl/rrts_checker.sv
tb/round_robin_thread_scheduler_core_test.sv
